### sv/cel_pkg.sv
// Shared types and codes for the compacting entry list.
package cel_pkg;

  localparam logic [1:0] STATUS_DONE      = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } cel_state_t;

  // Scan token handed from cell to cell.
  typedef struct packed {
    logic token;
    logic found;
  } cel_tok_t;

endpackage

### sv/cel_cell.sv
// One list cell: holds one entry and takes its neighbor's entry when the scan closes the gap.
module cel_cell #(
  parameter int BLOCK_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  write_en,
  input  logic [BLOCK_BITS-1:0] write_data,
  input  logic [BLOCK_BITS-1:0] key,
  input  logic                  live,
  input  logic [BLOCK_BITS-1:0] next_entry,
  input  cel_pkg::cel_tok_t     tok_in,
  output cel_pkg::cel_tok_t     tok_out,
  output logic [BLOCK_BITS-1:0] entry_out
);

  logic [BLOCK_BITS-1:0] entry_r;
  cel_pkg::cel_tok_t     tok_r;
  logic                  hit;
  logic                  shift;

  assign hit   = tok_r.token && live && (entry_r == key);
  assign shift = tok_r.token && live && (tok_r.found || (entry_r == key));

  assign tok_out.token = tok_r.token;
  assign tok_out.found = tok_r.found || hit;
  assign entry_out     = entry_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_in;
    end
  end

  // From the first live match on, every live cell takes its successor's entry as the token passes.
  always_ff @(posedge clk) begin
    if (write_en) begin
      entry_r <= write_data;
    end else if (shift) begin
      entry_r <= next_entry;
    end
  end

endmodule

### sv/compacting_entry_list.sv
// Top level of the compacting entry list: cell chain, scan control and result register.
//
// An ordered list of up to MAX_ENTRIES block numbers kept in a row of cells,
// one entry per cell, with a live count marking the end. An append (tuser 0)
// writes the cell at the live count and answers in the cycle after it is
// accepted, or reports full. A remove (tuser 1) launches a token that walks
// the chain one cell per cycle; the first live match and every live cell
// after it take their successor's entry. A remove answers only after the
// token has left the last cell, no matter where the match is, set by the
// length of the chain, and the next item can be accepted once that answer
// appears. One item is worked on at a time; a new item is accepted only
// when no result waits or in the cycle the waiting result is taken. Stored
// entries have no reset; only the live count and the control are cleared.
module compacting_entry_list #(
  parameter int MAX_ENTRIES = 255,
  parameter int BLOCK_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] block_number
  input  logic        in_tuser,   // [0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] entry_count
  output logic [1:0]  out_tuser   // [1:0] status
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

  cel_pkg::cel_state_t   state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [BLOCK_BITS-1:0] key_r;
  logic                  found_r, found_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [1:0]            out_status_r, out_status_nxt;
  logic [CNT_W-1:0]      out_count_r, out_count_nxt;

  logic                  accept;
  logic                  out_free;
  logic                  app_wr;
  logic [BLOCK_BITS+15:0] blk_ext;
  logic [BLOCK_BITS-1:0] in_key;
  logic [CNT_W+7:0]      cnt_ext;

  cel_pkg::cel_tok_t     tok   [MAX_ENTRIES+1];
  logic [BLOCK_BITS-1:0] entry [MAX_ENTRIES];

  assign blk_ext   = {{BLOCK_BITS{1'b0}}, in_tdata};
  assign in_key    = blk_ext[BLOCK_BITS-1:0];
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == cel_pkg::ST_IDLE) && out_free;
  assign accept    = in_tvalid && in_tready;
  assign app_wr    = accept && (in_tuser == cel_pkg::CMD_APPEND) && (count_r < MAX_CNT);

  // Launch the token into the first cell on a remove.
  assign tok[0].token = accept && (in_tuser == cel_pkg::CMD_REMOVE);
  assign tok[0].found = 1'b0;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic                  live;
    logic                  wr;
    logic [BLOCK_BITS-1:0] nxt_entry;

    assign live = count_r > CNT_W'(i);
    assign wr   = app_wr && (count_r == CNT_W'(i));
    if (i == MAX_ENTRIES - 1) begin : g_last
      assign nxt_entry = entry[i];
    end else begin : g_mid
      assign nxt_entry = entry[i+1];
    end

    cel_cell #(
      .BLOCK_BITS(BLOCK_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .write_en  (wr),
      .write_data(in_key),
      .key       (key_r),
      .live      (live),
      .next_entry(nxt_entry),
      .tok_in    (tok[i]),
      .tok_out   (tok[i+1]),
      .entry_out (entry[i])
    );
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    found_nxt      = found_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    case (state_r)
      cel_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_tuser == cel_pkg::CMD_REMOVE) begin
            state_nxt = cel_pkg::ST_SCAN;
          end else begin
            out_valid_nxt = 1'b1;
            if (count_r < MAX_CNT) begin
              count_nxt      = count_r + 1'b1;
              out_status_nxt = cel_pkg::STATUS_DONE;
              out_count_nxt  = count_r + 1'b1;
            end else begin
              out_status_nxt = cel_pkg::STATUS_FULL;
              out_count_nxt  = count_r;
            end
          end
        end
      end
      cel_pkg::ST_SCAN: begin
        // Wait for the token to leave the last cell.
        if (tok[MAX_ENTRIES].token) begin
          found_nxt = tok[MAX_ENTRIES].found;
          state_nxt = cel_pkg::ST_DONE;
        end
      end
      cel_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = cel_pkg::ST_IDLE;
          if (found_r) begin
            count_nxt      = count_r - 1'b1;
            out_status_nxt = cel_pkg::STATUS_DONE;
            out_count_nxt  = count_r - 1'b1;
          end else begin
            out_status_nxt = cel_pkg::STATUS_NOT_FOUND;
            out_count_nxt  = count_r;
          end
        end
      end
      default: begin
        state_nxt = cel_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cel_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_r <= in_key;
    end
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign cnt_ext    = {8'd0, out_count_r};
  assign out_tvalid = out_valid_r;
  assign out_tdata  = cnt_ext[7:0];
  assign out_tuser  = out_status_r;

endmodule

### tb/compacting_entry_list_checker.sv
// Stream monitor and scoreboard for the compacting entry list: predicts each answer and compares.
`timescale 1ns / 1ps

module compacting_entry_list_checker #(
  parameter int MAX_ENTRIES = 255,
  parameter int BLOCK_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] block_number
  input  logic        in_tuser,   // [0] cmd
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // [7:0] entry_count
  input  logic [1:0]  out_tuser,  // [1:0] status
  output int          mismatches,
  output int          outstanding
);

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] entry_count;
  } dir_answer_t;

  localparam logic [15:0] BLK_MASK =
    (BLOCK_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << BLOCK_BITS) - 32'd1);

  logic [15:0]  dir_entries [MAX_ENTRIES];
  int           live_len;
  dir_answer_t  pending_answers [$];
  int           err_count;

  assign mismatches = err_count;

  task automatic flag_mismatch(input string msg);
    err_count++;
    $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  // Apply one request to the shadow directory and return its answer.
  function automatic dir_answer_t apply_request(input logic cmd, input logic [15:0] blk);
    dir_answer_t ans;
    int          hit;
    ans.status = cel_pkg::STATUS_DONE;
    if (cmd == cel_pkg::CMD_APPEND) begin
      if (live_len >= MAX_ENTRIES) begin
        ans.status = cel_pkg::STATUS_FULL;
      end else begin
        dir_entries[live_len] = blk;
        live_len++;
      end
    end else begin
      hit = -1;
      // search live entries only; stale tail copies never match
      for (int i = 0; i < live_len; i++) begin
        if (hit < 0 && dir_entries[i] == blk) hit = i;
      end
      if (hit < 0) begin
        ans.status = cel_pkg::STATUS_NOT_FOUND;
      end else begin
        for (int i = hit; i + 1 < live_len; i++) dir_entries[i] = dir_entries[i + 1];
        live_len--;
      end
    end
    ans.entry_count = 8'(live_len);
    return ans;
  endfunction

  always @(posedge clk) begin
    dir_answer_t want;
    if (!rst_n) begin
      live_len = 0;
      pending_answers.delete();
    end else begin
      if (in_tvalid && in_tready)
        pending_answers.push_back(apply_request(in_tuser, in_tdata & BLK_MASK));
      if (out_tvalid && out_tready) begin
        if (pending_answers.size() == 0) begin
          flag_mismatch($sformatf("unexpected answer status=%0d count=%0d",
                                  out_tuser, out_tdata));
        end else begin
          want = pending_answers.pop_front();
          if (out_tuser !== want.status)
            flag_mismatch($sformatf("status got %0d want %0d", out_tuser, want.status));
          if (out_tdata !== want.entry_count)
            flag_mismatch($sformatf("entry_count got %0d want %0d",
                                    out_tdata, want.entry_count));
        end
      end
    end
    outstanding <= pending_answers.size();
  end

endmodule

### tb/compacting_entry_list_tb.sv
// Top of the compacting entry list testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module compacting_entry_list_tb;

  localparam int MAX_ENTRIES  = 255;
  localparam int BLOCK_BITS   = 16;
  localparam int RANDOM_ITEMS = 1750;
  localparam int PHASE_LEN    = 350;
  localparam int STALL_LIMIT  = 5000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        in_tuser = cel_pkg::CMD_APPEND;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic [1:0]  out_tuser;

  int          mismatches;
  int          outstanding;
  int          stall_cycles = 0;
  logic        calm = 1'b0;
  logic [15:0] live_vals [$];
  logic [15:0] value_pool [8] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000,
                                  16'h00FF, 16'hFF00, 16'h1234, 16'h4321};

  always #5 clk = ~clk;

  compacting_entry_list #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .BLOCK_BITS (BLOCK_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  compacting_entry_list_checker #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .BLOCK_BITS (BLOCK_BITS)
  ) list_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 35);
  end

  // Count cycles with no item moving on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("compacting_entry_list_tb NOT OK");
        $finish;
      end
    end
  end

  // Offer one request, wait for it to be taken, then track the live values.
  task automatic send_item(input logic cmd, input logic [15:0] blk);
    while (!calm && $urandom_range(99) < 35) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= blk;
    in_tuser  <= cmd;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (cmd == cel_pkg::CMD_APPEND) begin
      if (live_vals.size() < MAX_ENTRIES) live_vals.push_back(blk);
    end else begin
      for (int i = 0; i < live_vals.size(); i++) begin
        if (live_vals[i] == blk) begin
          live_vals.delete(i);
          break;
        end
      end
    end
  endtask

  function automatic logic [15:0] pick_value();
    if ($urandom_range(1) == 0) return value_pool[$urandom_range(7)];
    return 16'($urandom);
  endfunction

  // Remove: mostly a value that is live, otherwise anything.
  function automatic logic [15:0] pick_victim(input int hit_pct);
    if (live_vals.size() > 0 && $urandom_range(99) < hit_pct)
      return live_vals[$urandom_range(live_vals.size() - 1)];
    return pick_value();
  endfunction

  initial begin
    int remove_pct;
    int hit_pct;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(cel_pkg::CMD_REMOVE, 16'h0000);  // remove on an empty list
    send_item(cel_pkg::CMD_APPEND, 16'h0000);
    send_item(cel_pkg::CMD_APPEND, 16'hFFFF);
    send_item(cel_pkg::CMD_APPEND, 16'h1234);
    send_item(cel_pkg::CMD_APPEND, 16'h8001);
    send_item(cel_pkg::CMD_APPEND, 16'h1234);  // duplicate
    send_item(cel_pkg::CMD_APPEND, 16'h7FFE);
    send_item(cel_pkg::CMD_APPEND, 16'h5555);
    send_item(cel_pkg::CMD_APPEND, 16'hAAAA);
    send_item(cel_pkg::CMD_REMOVE, 16'h1234);  // first of the duplicates only
    send_item(cel_pkg::CMD_REMOVE, 16'h1234);
    send_item(cel_pkg::CMD_REMOVE, 16'h1234);  // no match left
    send_item(cel_pkg::CMD_REMOVE, 16'h0000);  // head entry
    send_item(cel_pkg::CMD_REMOVE, 16'hAAAA);  // tail entry, leaves a stale copy
    send_item(cel_pkg::CMD_REMOVE, 16'hAAAA);  // stale copy must not match
    send_item(cel_pkg::CMD_REMOVE, 16'hFFFF);
    send_item(cel_pkg::CMD_APPEND, 16'hAAAA);
    send_item(cel_pkg::CMD_REMOVE, 16'h7FFE);  // middle entry
    send_item(cel_pkg::CMD_REMOVE, 16'h4242);  // miss on a non-empty list
    send_item(cel_pkg::CMD_REMOVE, 16'h8001);
    send_item(cel_pkg::CMD_REMOVE, 16'h5555);
    send_item(cel_pkg::CMD_REMOVE, 16'hAAAA);  // list now empty
    send_item(cel_pkg::CMD_REMOVE, 16'h5555);  // stale value on an empty list
    send_item(cel_pkg::CMD_APPEND, 16'hFFFF);
    send_item(cel_pkg::CMD_REMOVE, 16'hFFFF);

    // Phases: fill to full, drain to empty, mixed noise, fill, drain.
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      calm <= (k >= 700 && k < 1000);
      case ((k / PHASE_LEN) % 5)
        0, 3: begin remove_pct = 10; hit_pct = 70; end
        1, 4: begin remove_pct = 95; hit_pct = 85; end
        default: begin remove_pct = 50; hit_pct = 55; end
      endcase
      if ($urandom_range(99) < remove_pct) send_item(cel_pkg::CMD_REMOVE, pick_victim(hit_pct));
      else send_item(cel_pkg::CMD_APPEND, pick_value());
    end
    in_tvalid <= 1'b0;
    calm      <= 1'b0;

    // Let the checker count the last item before waiting on it.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (MAX_ENTRIES + 10) @(posedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("compacting_entry_list_tb OK");
    end else begin
      $display("compacting_entry_list_tb NOT OK");
    end
    $finish;
  end

endmodule
